// ===== rtl/weighted_running_mean_variance_assert.svh =====
// Assertion macros for the weighted running mean and variance block.
// Used by the port checker; expects clk_i and rst_ni in scope.
`ifndef WEIGHTED_RUNNING_MEAN_VARIANCE_ASSERT_SVH
`define WEIGHTED_RUNNING_MEAN_VARIANCE_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define WRMV_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Condition implies consequence in the next cycle.
`define WRMV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/wrmv_pkg.sv =====
// Shared widths, constants and the sequencer state type for the weighted
// running mean and variance block. No dependencies.
`default_nettype none

package wrmv_pkg;

  // Field and accumulator widths
  localparam int VALUE_WIDTH_DEF = 32;  // sample width, Q16.16
  localparam int WEIGHT_W        = 16;  // Q8.8 weight
  localparam int WEIGHT_FRAC     = 8;
  localparam int WT_W            = 32;  // weight sum, Q24.8
  localparam int WSQ_W           = 48;  // squared weight sum, Q32.16
  localparam int DEV_W           = 64;  // deviation square sum
  localparam int MEAN_W          = 32;  // mean output
  localparam int VAR_W           = 48;  // variance output, Q32.16
  localparam int VAR_FRAC        = 16;
  localparam int DEV_SPLIT       = VAR_W - VAR_FRAC;
  localparam int DEN_W           = 40;  // positive denominator magnitude
  localparam int DVS_W           = 40;  // divisor width of the serial divider
  localparam int TERM_SHIFT      = 24;  // weight frac plus value frac
  localparam int EXT_W           = 128; // room for any product width
  localparam int FREQ_OFFSET     = 65536; // one, with 16 fraction bits

  localparam logic FREQ_RESET = 1'b1;

  // Sequencer states, one-hot
  typedef enum logic [10:0] {
    ST_IDLE = 11'b000_0000_0001,
    ST_PREP = 11'b000_0000_0010,
    ST_MULW = 11'b000_0000_0100,
    ST_MDIV = 11'b000_0000_1000,
    ST_DIFF = 11'b000_0001_0000,
    ST_MUL  = 11'b000_0010_0000,
    ST_DEN  = 11'b000_0100_0000,
    ST_RDIV = 11'b000_1000_0000,
    ST_CHK  = 11'b001_0000_0000,
    ST_VDIV = 11'b010_0000_0000,
    ST_RES  = 11'b100_0000_0000
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/wrmv_serial_div.sv =====
// Restoring divider, one quotient bit per cycle, with a preset partial
// remainder. Depends on wrmv_pkg for default widths.
`default_nettype none

module wrmv_serial_div #(
  parameter int DVS_W = wrmv_pkg::DVS_W,
  parameter int QUO_W = wrmv_pkg::VAR_W,
  parameter int CNT_W = $clog2(QUO_W + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [CNT_W-1:0] steps_i,
  input  wire logic [DVS_W-1:0] rem_init_i,
  input  wire logic [QUO_W-1:0] dividend_i,
  input  wire logic [DVS_W-1:0] divisor_i,
  output logic                  done_o,
  output logic [QUO_W-1:0]      quotient_o
);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVS_W-1:0] rem_q, rem_d, dvs_q;
  logic [QUO_W-1:0] quo_q, quo_d;
  logic [DVS_W:0]   trial, diff;
  logic             fits;

  // Shift one dividend bit into the remainder, subtract when it fits
  always_comb begin
    trial = {rem_q, quo_q[QUO_W-1]};
    diff  = trial - {1'b0, dvs_q};
    fits  = trial >= {1'b0, dvs_q};
    rem_d = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    quo_d = {quo_q[QUO_W-2:0], fits};
  end

  // Step counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= steps_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Load operands, then advance one bit a cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_init_i;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ===== rtl/wrmv_serial_mul.sv =====
// Shift-add multiplier, one multiplier bit per cycle, product shifted in
// from the top. Depends on wrmv_pkg for default widths.
`default_nettype none

module wrmv_serial_mul #(
  parameter int MC_W   = wrmv_pkg::VALUE_WIDTH_DEF + wrmv_pkg::WEIGHT_W,
  parameter int MP_W   = wrmv_pkg::VALUE_WIDTH_DEF,
  parameter int PROD_W = MC_W + MP_W,
  parameter int CNT_W  = $clog2(MP_W + 1)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [MC_W-1:0] multiplicand_i,
  input  wire logic [MP_W-1:0] multiplier_i,
  output logic                 done_o,
  output logic [PROD_W-1:0]    product_o
);

  logic              busy_q, done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [MC_W-1:0]   mc_q;
  logic [PROD_W-1:0] acc_q, acc_d;
  logic [MC_W:0]     upper;

  // Add the multiplicand when the low bit is set, then shift right
  always_comb begin
    upper = {1'b0, acc_q[PROD_W-1:MP_W]} + (acc_q[0] ? {1'b0, mc_q} : '0);
    acc_d = {upper, acc_q[MP_W-1:1]};
  end

  // Step counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(MP_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Load operands, then advance one bit a cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mc_q  <= multiplicand_i;
      acc_q <= PROD_W'(multiplier_i);
    end else if (busy_q) begin
      acc_q <= acc_d;
    end
  end

  assign done_o    = done_q;
  assign product_o = acc_q;

endmodule

`default_nettype wire

// ===== rtl/weighted_running_mean_variance.sv =====
// Weighted running mean and variance (West's incremental update), top level.
// Depends on wrmv_pkg, wrmv_serial_div and wrmv_serial_mul.
//
//   Channel  Handshake                  Word
//   input    in_valid_i / in_stall_o    sample_value_i, sample_weight_i, last_sample_i
//   output   out_valid_o / out_stall_i  mean_out_o, variance_out_o, variance_invalid_o,
//                                       variance_saturated_o
//   config   cfg_we_i                   cfg_wdata_i (frequency_weights)
//
// A word not marked last runs a bit-serial mean divide and a deviation multiply of VALUE_WIDTH
// steps each; the mean divide is skipped while the weight sum is zero. A last word then adds
// the reliability denominator division (frequency_weights 0, weight sum not zero) and the
// variance division (denominator positive, quotient in range). Reset is asynchronous:
// frequency_weights returns to 1 and all sums clear. A result waits in the output register
// while a new word is accepted; a last word holds in its final state until that register is free.
`default_nettype none

module weighted_running_mean_variance #(
  parameter int VALUE_WIDTH = wrmv_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic                              cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic signed [VALUE_WIDTH-1:0]     sample_value_i,
  input  wire logic [wrmv_pkg::WEIGHT_W-1:0]     sample_weight_i,
  input  wire logic                              last_sample_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [wrmv_pkg::MEAN_W-1:0]     mean_out_o,
  output logic [wrmv_pkg::VAR_W-1:0]             variance_out_o,
  output logic                                   variance_invalid_o,
  output logic                                   variance_saturated_o
);

  localparam int VW     = VALUE_WIDTH;
  localparam int NUM_W  = VW + wrmv_pkg::WEIGHT_W;
  localparam int PROD_W = NUM_W + VW;
  localparam int QUO_W  = (VW > wrmv_pkg::VAR_W) ? VW : wrmv_pkg::VAR_W;
  localparam int CNT_W  = $clog2(QUO_W + 1);
  localparam int DVS_W  = wrmv_pkg::DVS_W;
  localparam int DEN_W  = wrmv_pkg::DEN_W;
  localparam int DEV_W  = wrmv_pkg::DEV_W;
  localparam int WT_W   = wrmv_pkg::WT_W;
  localparam int WSQ_W  = wrmv_pkg::WSQ_W;
  localparam int VAR_W  = wrmv_pkg::VAR_W;
  localparam int EXT_W  = wrmv_pkg::EXT_W;
  localparam int TSH    = wrmv_pkg::TERM_SHIFT;
  localparam int SPLIT  = wrmv_pkg::DEV_SPLIT;
  localparam int WFRAC  = wrmv_pkg::WEIGHT_FRAC;

  // Control and running state
  wrmv_pkg::state_e state_q, state_d;
  logic             freq_q;
  logic             div_start_q, div_start_d;
  logic             mul_start_q, mul_start_d;
  logic             out_valid_q, out_valid_d;
  logic [WT_W-1:0]  wt_q, wt_d;
  logic [WSQ_W-1:0] wsq_q, wsq_d;
  logic [VW-1:0]    mean_q, mean_d;
  logic [DEV_W-1:0] dev_q, dev_d;

  // Per-word payload
  logic [VW-1:0]                 x_q, x_d;
  logic [wrmv_pkg::WEIGHT_W-1:0] w_q, w_d;
  logic                          last_q, last_d;
  logic [VW-1:0]                 a1_q, a1_d, a2_q, a2_d;
  logic                          neg_q, neg_d;
  logic [NUM_W-1:0]              num_q, num_d;
  logic [DEN_W:0]                den_q, den_d;
  logic [VAR_W-1:0]              res_var_q, res_var_d;
  logic                          res_inv_q, res_inv_d, res_sat_q, res_sat_d;
  logic [wrmv_pkg::MEAN_W-1:0]   mean_out_q, mean_out_d;
  logic [VAR_W-1:0]              var_out_q, var_out_d;
  logic                          inv_out_q, inv_out_d, sat_out_q, sat_out_d;

  // Serial unit connections
  logic [DVS_W-1:0]  div_rem_init, div_divisor;
  logic [QUO_W-1:0]  div_dividend, div_quo;
  logic [CNT_W-1:0]  div_steps;
  logic              div_done;
  logic              mul_done;
  logic [PROD_W-1:0] mul_prod;

  // Datapath helpers
  logic [WT_W:0]         wt_sum;
  logic [31:0]           w_sq;
  logic [WSQ_W:0]        wsq_sum;
  logic [VW:0]           diff, diff_mag;
  logic [NUM_W-1:0]      aw_prod;
  logic [VW:0]           mean_ext, mean_next;
  logic [EXT_W-1:0]      prod_ext;
  logic [DEV_W-1:0]      term;
  logic [DEV_W:0]        dev_sum;
  logic [DEN_W:0]        wt_scaled, den_freq, den_rel;
  logic                  den_nonpos, var_ovf;
  logic                  out_free;

  // Sums, difference to the mean and the saturating accumulations
  always_comb begin
    wt_sum    = {1'b0, wt_q} + (WT_W + 1)'(w_q);
    w_sq      = 32'(w_q) * 32'(w_q);
    wsq_sum   = {1'b0, wsq_q} + (WSQ_W + 1)'(w_sq);
    diff      = {x_q[VW-1], x_q} - {mean_q[VW-1], mean_q};
    diff_mag  = diff[VW] ? ((VW + 1)'(0) - diff) : diff;
    aw_prod   = NUM_W'(a1_q) * NUM_W'(w_q);
    mean_ext  = {mean_q[VW-1], mean_q};
    mean_next = neg_q ? (mean_ext - {1'b0, div_quo[VW-1:0]})
                      : (mean_ext + {1'b0, div_quo[VW-1:0]});
    prod_ext  = EXT_W'(mul_prod);
    term      = (|prod_ext[EXT_W-1:DEV_W+TSH]) ? '1 : prod_ext[DEV_W+TSH-1:TSH];
    dev_sum   = {1'b0, dev_q} + {1'b0, term};
    wt_scaled = (DEN_W + 1)'(wt_q) << WFRAC;
    den_freq  = wt_scaled - (DEN_W + 1)'(wrmv_pkg::FREQ_OFFSET);
    den_rel   = wt_scaled - {1'b0, div_quo[DEN_W-1:0]};
    den_nonpos = den_q[DEN_W] || (den_q == '0);
    var_ovf   = DEN_W'(dev_q[DEV_W-1:SPLIT]) >= den_q[DEN_W-1:0];
    out_free  = !out_valid_q || !out_stall_i;
  end

  // Route the shared divider by phase
  always_comb begin
    case (state_q)
      wrmv_pkg::ST_RDIV: begin
        div_rem_init = DVS_W'(wsq_q[WSQ_W-1:DEN_W-WFRAC]);
        div_dividend = QUO_W'({wsq_q[DEN_W-WFRAC-1:0], {WFRAC{1'b0}}}) << (QUO_W - DEN_W);
        div_divisor  = DVS_W'(wt_q);
        div_steps    = CNT_W'(DEN_W);
      end
      wrmv_pkg::ST_VDIV: begin
        div_rem_init = DVS_W'(dev_q[DEV_W-1:SPLIT]);
        div_dividend = QUO_W'({dev_q[SPLIT-1:0], {wrmv_pkg::VAR_FRAC{1'b0}}})
                       << (QUO_W - VAR_W);
        div_divisor  = den_q[DEN_W-1:0];
        div_steps    = CNT_W'(VAR_W);
      end
      default: begin
        div_rem_init = DVS_W'(num_q[NUM_W-1:VW]);
        div_dividend = QUO_W'(num_q[VW-1:0]) << (QUO_W - VW);
        div_divisor  = DVS_W'(wt_q);
        div_steps    = CNT_W'(VW);
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    div_start_d = 1'b0;
    mul_start_d = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    wt_d        = wt_q;
    wsq_d       = wsq_q;
    mean_d      = mean_q;
    dev_d       = dev_q;
    x_d         = x_q;
    w_d         = w_q;
    last_d      = last_q;
    a1_d        = a1_q;
    a2_d        = a2_q;
    neg_d       = neg_q;
    num_d       = num_q;
    den_d       = den_q;
    res_var_d   = res_var_q;
    res_inv_d   = res_inv_q;
    res_sat_d   = res_sat_q;
    mean_out_d  = mean_out_q;
    var_out_d   = var_out_q;
    inv_out_d   = inv_out_q;
    sat_out_d   = sat_out_q;

    case (state_q)
      // Take a word
      wrmv_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          x_d     = sample_value_i;
          w_d     = sample_weight_i;
          last_d  = last_sample_i;
          state_d = wrmv_pkg::ST_PREP;
        end
      end
      // Add the weight and its square, take the first difference
      wrmv_pkg::ST_PREP: begin
        wt_d    = wt_sum[WT_W] ? '1 : wt_sum[WT_W-1:0];
        wsq_d   = wsq_sum[WSQ_W] ? '1 : wsq_sum[WSQ_W-1:0];
        a1_d    = diff_mag[VW-1:0];
        neg_d   = diff[VW];
        state_d = wrmv_pkg::ST_MULW;
      end
      // Weight the difference; skip the mean step on a zero weight sum
      wrmv_pkg::ST_MULW: begin
        num_d = aw_prod;
        if (wt_q != '0) begin
          div_start_d = 1'b1;
          state_d     = wrmv_pkg::ST_MDIV;
        end else begin
          state_d = wrmv_pkg::ST_DIFF;
        end
      end
      // Move the mean toward the sample
      wrmv_pkg::ST_MDIV: begin
        if (div_done) begin
          mean_d  = mean_next[VW-1:0];
          state_d = wrmv_pkg::ST_DIFF;
        end
      end
      // Second difference against the new mean
      wrmv_pkg::ST_DIFF: begin
        a2_d        = diff_mag[VW-1:0];
        mul_start_d = 1'b1;
        state_d     = wrmv_pkg::ST_MUL;
      end
      // Accumulate the weighted square deviation
      wrmv_pkg::ST_MUL: begin
        if (mul_done) begin
          dev_d   = dev_sum[DEV_W] ? '1 : dev_sum[DEV_W-1:0];
          state_d = last_q ? wrmv_pkg::ST_DEN : wrmv_pkg::ST_IDLE;
        end
      end
      // Form the variance denominator
      wrmv_pkg::ST_DEN: begin
        if (freq_q) begin
          den_d   = den_freq;
          state_d = wrmv_pkg::ST_CHK;
        end else if (wt_q == '0) begin
          res_var_d = '0;
          res_inv_d = 1'b1;
          res_sat_d = 1'b0;
          state_d   = wrmv_pkg::ST_RES;
        end else begin
          div_start_d = 1'b1;
          state_d     = wrmv_pkg::ST_RDIV;
        end
      end
      wrmv_pkg::ST_RDIV: begin
        if (div_done) begin
          den_d   = den_rel;
          state_d = wrmv_pkg::ST_CHK;
        end
      end
      // Flag a bad denominator or an out-of-range quotient, else divide
      wrmv_pkg::ST_CHK: begin
        if (den_nonpos) begin
          res_var_d = '0;
          res_inv_d = 1'b1;
          res_sat_d = 1'b0;
          state_d   = wrmv_pkg::ST_RES;
        end else if (var_ovf) begin
          res_var_d = '1;
          res_inv_d = 1'b0;
          res_sat_d = 1'b1;
          state_d   = wrmv_pkg::ST_RES;
        end else begin
          div_start_d = 1'b1;
          state_d     = wrmv_pkg::ST_VDIV;
        end
      end
      wrmv_pkg::ST_VDIV: begin
        if (div_done) begin
          res_var_d = div_quo[VAR_W-1:0];
          res_inv_d = 1'b0;
          res_sat_d = 1'b0;
          state_d   = wrmv_pkg::ST_RES;
        end
      end
      // Hand the result to the output register and clear the sums
      wrmv_pkg::ST_RES: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          mean_out_d  = wrmv_pkg::MEAN_W'($signed(mean_q));
          var_out_d   = res_var_q;
          inv_out_d   = res_inv_q;
          sat_out_d   = res_sat_q;
          wt_d        = '0;
          wsq_d       = '0;
          mean_d      = '0;
          dev_d       = '0;
          state_d     = wrmv_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = wrmv_pkg::ST_IDLE;
      end
    endcase
  end

  // Control and running sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wrmv_pkg::ST_IDLE;
      freq_q      <= wrmv_pkg::FREQ_RESET;
      div_start_q <= 1'b0;
      mul_start_q <= 1'b0;
      out_valid_q <= 1'b0;
      wt_q        <= '0;
      wsq_q       <= '0;
      mean_q      <= '0;
      dev_q       <= '0;
    end else begin
      state_q     <= state_d;
      div_start_q <= div_start_d;
      mul_start_q <= mul_start_d;
      out_valid_q <= out_valid_d;
      wt_q        <= wt_d;
      wsq_q       <= wsq_d;
      mean_q      <= mean_d;
      dev_q       <= dev_d;
      if (cfg_we_i) begin
        freq_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    w_q        <= w_d;
    last_q     <= last_d;
    a1_q       <= a1_d;
    a2_q       <= a2_d;
    neg_q      <= neg_d;
    num_q      <= num_d;
    den_q      <= den_d;
    res_var_q  <= res_var_d;
    res_inv_q  <= res_inv_d;
    res_sat_q  <= res_sat_d;
    mean_out_q <= mean_out_d;
    var_out_q  <= var_out_d;
    inv_out_q  <= inv_out_d;
    sat_out_q  <= sat_out_d;
  end

  // Shared divider: mean step, reliability correction, variance
  wrmv_serial_div #(
    .DVS_W (DVS_W),
    .QUO_W (QUO_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .steps_i    (div_steps),
    .rem_init_i (div_rem_init),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Deviation product: weight times first difference times second difference
  wrmv_serial_mul #(
    .MC_W   (NUM_W),
    .MP_W   (VW),
    .PROD_W (PROD_W),
    .CNT_W  ($clog2(VW + 1))
  ) u_mul (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (mul_start_q),
    .multiplicand_i (num_q),
    .multiplier_i   (a2_q),
    .done_o         (mul_done),
    .product_o      (mul_prod)
  );

  assign in_stall_o           = (state_q != wrmv_pkg::ST_IDLE);
  assign out_valid_o          = out_valid_q;
  assign mean_out_o           = mean_out_q;
  assign variance_out_o       = var_out_q;
  assign variance_invalid_o   = inv_out_q;
  assign variance_saturated_o = sat_out_q;

endmodule

`default_nettype wire

// ===== rtl/wrmv_checker.sv =====
// Port checker for the weighted running mean and variance block, bound to
// the top level. Depends on wrmv_pkg and the assertion macro header.
`default_nettype none
`include "weighted_running_mean_variance_assert.svh"

module wrmv_checker (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               in_valid_i,
  input wire logic                               in_stall_o,
  input wire logic                               out_valid_o,
  input wire logic                               out_stall_i,
  input wire logic [wrmv_pkg::MEAN_W-1:0]        mean_out_o,
  input wire logic [wrmv_pkg::VAR_W-1:0]         variance_out_o,
  input wire logic                               variance_invalid_o,
  input wire logic                               variance_saturated_o
);

  // Hold a stalled result word
  `WRMV_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(mean_out_o) && $stable(variance_out_o) && $stable(variance_invalid_o) && $stable(variance_saturated_o), "result word changed while stalled")

  // Busy right after taking a word
  `WRMV_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "input taken again without processing")

  // Flags exclude each other
  `WRMV_ASSERT_IMPLIES(a_flags_excl, out_valid_o, !(variance_invalid_o && variance_saturated_o), "invalid and saturated both set")

  // Bad denominator reads as zero variance
  `WRMV_ASSERT_IMPLIES(a_invalid_zero, out_valid_o && variance_invalid_o, variance_out_o == '0, "invalid variance not zero")

  // Clamped variance reads as all ones
  `WRMV_ASSERT_IMPLIES(a_sat_max, out_valid_o && variance_saturated_o, &variance_out_o, "saturated variance not at maximum")

endmodule

bind weighted_running_mean_variance wrmv_checker u_wrmv_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .in_valid_i           (in_valid_i),
  .in_stall_o           (in_stall_o),
  .out_valid_o          (out_valid_o),
  .out_stall_i          (out_stall_i),
  .mean_out_o           (mean_out_o),
  .variance_out_o       (variance_out_o),
  .variance_invalid_o   (variance_invalid_o),
  .variance_saturated_o (variance_saturated_o)
);

`default_nettype wire
